// ===== src/pwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsl_pkg
// Shared widths, configuration register indexes and types of the PID unit.
// ----------------------------------------------------------------------------
package pwsl_pkg;

    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 23;
    localparam int DRIVE_W     = 24;
    localparam int SUM_W       = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = LIMIT_W;

    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_FRAC_BITS    = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_P     = 2'd0,
        CFG_GAIN_I     = 2'd1,
        CFG_GAIN_D     = 2'd2,
        CFG_RATE_LIMIT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
    } gains_t;

endpackage

// ===== src/pwsl_error_stage.sv =====
// ----------------------------------------------------------------------------
// pwsl_error_stage
// Input register, then error, saturating error sum and error difference.
// ----------------------------------------------------------------------------
module pwsl_error_stage
    import pwsl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_WIDTH-1:0]     target,
    input  logic [SAMPLE_WIDTH-1:0]     measured,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_WIDTH:0]   error,
    output logic signed [SUM_W-1:0]        error_sum,
    output logic signed [SAMPLE_WIDTH+1:0] delta
);

    localparam int EXT_W = ((SAMPLE_WIDTH + 1 > SUM_W) ? SAMPLE_WIDTH + 1 : SUM_W) + 1;

    logic                          in_valid_reg;
    logic                          in_valid_next;
    logic signed [SAMPLE_WIDTH-1:0] target_reg;
    logic signed [SAMPLE_WIDTH-1:0] measured_reg;

    logic                            valid_reg;
    logic                            valid_next;
    logic signed [SAMPLE_WIDTH:0]    error_reg;
    logic signed [SAMPLE_WIDTH:0]    error_next;
    logic signed [SUM_W-1:0]         sum_reg;
    logic signed [SUM_W-1:0]         sum_next;
    logic signed [SAMPLE_WIDTH+1:0]  delta_reg;
    logic signed [SAMPLE_WIDTH+1:0]  delta_next;

    logic                            ready_1;
    logic                            load_0;
    logic                            load_1;
    logic signed [EXT_W-1:0]         sum_wide;

    assign ready_1  = !valid_reg || out_ready;
    assign in_ready = !in_valid_reg || ready_1;
    assign load_0   = in_valid && in_ready;
    assign load_1   = in_valid_reg && ready_1;

    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
        valid_next    = ready_1 ? in_valid_reg : valid_reg;
    end

    // The error register doubles as the previous error once its item moves on.
    always_comb
    begin
        error_next = (SAMPLE_WIDTH + 1)'(target_reg) - (SAMPLE_WIDTH + 1)'(measured_reg);
        delta_next = (SAMPLE_WIDTH + 2)'(error_next) - (SAMPLE_WIDTH + 2)'(error_reg);
        sum_wide   = EXT_W'(sum_reg) + EXT_W'(error_next);
        if (sum_wide[EXT_W-1:SUM_W-1] == '0 || sum_wide[EXT_W-1:SUM_W-1] == '1)
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        else if (sum_wide[EXT_W-1])
        begin
            sum_next = {1'b1, {(SUM_W-1){1'b0}}};
        end
        else
        begin
            sum_next = {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            valid_reg    <= 1'b0;
            error_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            valid_reg    <= valid_next;
            if (load_1)
            begin
                error_reg <= error_next;
                sum_reg   <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_0)
        begin
            target_reg   <= target;
            measured_reg <= measured;
        end
        if (load_1)
        begin
            delta_reg <= delta_next;
        end
    end

    assign out_valid = valid_reg;
    assign error     = error_reg;
    assign error_sum = sum_reg;
    assign delta     = delta_reg;

endmodule

// ===== src/pwsl_mult_stage.sv =====
// ----------------------------------------------------------------------------
// pwsl_mult_stage
// Three gain products, each registered.
// ----------------------------------------------------------------------------
module pwsl_mult_stage
    import pwsl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gains_t                            gains,
    input  logic signed [SAMPLE_WIDTH:0]      error,
    input  logic signed [SUM_W-1:0]           error_sum,
    input  logic signed [SAMPLE_WIDTH+1:0]    delta,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [GAIN_W+SAMPLE_WIDTH:0]   prod_p,
    output logic signed [GAIN_W+SUM_W-1:0]        prod_i,
    output logic signed [GAIN_W+SAMPLE_WIDTH+1:0] prod_d
);

    logic                                     valid_reg;
    logic                                     valid_next;
    logic                                     load;
    logic signed [GAIN_W+SAMPLE_WIDTH:0]      prod_p_reg;
    logic signed [GAIN_W+SAMPLE_WIDTH:0]      prod_p_next;
    logic signed [GAIN_W+SUM_W-1:0]           prod_i_reg;
    logic signed [GAIN_W+SUM_W-1:0]           prod_i_next;
    logic signed [GAIN_W+SAMPLE_WIDTH+1:0]    prod_d_reg;
    logic signed [GAIN_W+SAMPLE_WIDTH+1:0]    prod_d_next;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next  = in_ready ? in_valid : valid_reg;
        prod_p_next = gains.kp * error;
        prod_i_next = gains.ki * error_sum;
        prod_d_next = gains.kd * delta;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod_p    = prod_p_reg;
    assign prod_i    = prod_i_reg;
    assign prod_d    = prod_d_reg;

endmodule

// ===== src/pwsl_sum_stage.sv =====
// ----------------------------------------------------------------------------
// pwsl_sum_stage
// Sum of products, arithmetic shift by the gain fraction, saturation to drive.
// ----------------------------------------------------------------------------
module pwsl_sum_stage
    import pwsl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [GAIN_W+SAMPLE_WIDTH:0]   prod_p,
    input  logic signed [GAIN_W+SUM_W-1:0]        prod_i,
    input  logic signed [GAIN_W+SAMPLE_WIDTH+1:0] prod_d,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [DRIVE_W-1:0]             drive
);

    localparam int WIDE_W = (GAIN_W + SAMPLE_WIDTH + 2 > GAIN_W + SUM_W) ?
                            GAIN_W + SAMPLE_WIDTH + 2 : GAIN_W + SUM_W;
    localparam int ACC_W  = WIDE_W + 2;

    logic                        valid_reg;
    logic                        valid_next;
    logic                        load;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     shifted;
    logic signed [DRIVE_W-1:0]   drive_reg;
    logic signed [DRIVE_W-1:0]   drive_next;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // The arithmetic shift rounds toward minus infinity.
    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
        acc        = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
        shifted    = acc >>> FRAC_BITS;
        if (shifted[ACC_W-1:DRIVE_W-1] == '0 || shifted[ACC_W-1:DRIVE_W-1] == '1)
        begin
            drive_next = shifted[DRIVE_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            drive_next = {1'b1, {(DRIVE_W-1){1'b0}}};
        end
        else
        begin
            drive_next = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid = valid_reg;
    assign drive     = drive_reg;

endmodule

// ===== src/pwsl_slew_stage.sv =====
// ----------------------------------------------------------------------------
// pwsl_slew_stage
// Slew limit against the previous drive, and the output register.
// ----------------------------------------------------------------------------
module pwsl_slew_stage
    import pwsl_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [DRIVE_W-1:0]   drive_in,
    input  logic [LIMIT_W-1:0]          rate_limit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [DRIVE_W-1:0]   drive,
    output logic                        rate_limited
);

    localparam int BOUND_W = DRIVE_W + 2;

    logic                        valid_reg;
    logic                        valid_next;
    logic                        load;
    logic signed [DRIVE_W-1:0]   drive_reg;
    logic signed [DRIVE_W-1:0]   drive_next;
    logic                        limited_reg;
    logic                        limited_next;
    logic signed [BOUND_W-1:0]   upper;
    logic signed [BOUND_W-1:0]   lower;
    logic signed [BOUND_W-1:0]   drive_wide;
    logic signed [BOUND_W-1:0]   limit_wide;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // The output register keeps the last drive, which is the slew reference.
    always_comb
    begin
        valid_next   = in_ready ? in_valid : valid_reg;
        limit_wide   = BOUND_W'({1'b0, rate_limit});
        drive_wide   = BOUND_W'(drive_in);
        upper        = BOUND_W'(drive_reg) + limit_wide;
        lower        = BOUND_W'(drive_reg) - limit_wide;
        drive_next   = drive_in;
        limited_next = 1'b0;
        priority if (rate_limit != '0 && drive_wide > upper)
        begin
            drive_next   = upper[DRIVE_W-1:0];
            limited_next = 1'b1;
        end
        else if (rate_limit != '0 && drive_wide < lower)
        begin
            drive_next   = lower[DRIVE_W-1:0];
            limited_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            drive_reg   <= '0;
            limited_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (load)
            begin
                drive_reg   <= drive_next;
                limited_reg <= limited_next;
            end
        end
    end

    assign out_valid    = valid_reg;
    assign drive        = drive_reg;
    assign rate_limited = limited_reg;

endmodule

// ===== src/pid_with_slew_limit_unit.sv =====
// ----------------------------------------------------------------------------
// pid_with_slew_limit_unit
// Positional PID step with saturating integral and an optional slew limit.
// ----------------------------------------------------------------------------
// Each transaction on the input stream carries a target and a measured sample
// and yields exactly one drive value on the output stream, in order. The unit
// is a five-register pipeline (input, error and sum, products, scaled sum,
// slew limit) and accepts one sample per cycle while the output side does not
// stall. The error sum and the previous drive are each updated within one
// stage, so successive samples need no spacing. Gains and the rate limit are
// to be written through the configuration channel only while no sample is in
// flight; the unit itself does not enforce this. A zero rate limit disables
// slew limiting.
// ----------------------------------------------------------------------------
module pid_with_slew_limit_unit
    import pwsl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS,
    localparam int IN_DATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_W-1:0]    s_tdata,   // target, measured
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [DRIVE_W-1:0]      m_tdata,   // drive
    output logic                    m_tuser,   // rate_limited
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    gains_t                       gains_reg;
    gains_t                       gains_next;
    logic [LIMIT_W-1:0]           rate_limit_reg;
    logic [LIMIT_W-1:0]           rate_limit_next;

    logic                                  err_valid;
    logic                                  err_ready;
    logic signed [SAMPLE_WIDTH:0]          error;
    logic signed [SUM_W-1:0]               error_sum;
    logic signed [SAMPLE_WIDTH+1:0]        delta;

    logic                                  mul_valid;
    logic                                  mul_ready;
    logic signed [GAIN_W+SAMPLE_WIDTH:0]   prod_p;
    logic signed [GAIN_W+SUM_W-1:0]        prod_i;
    logic signed [GAIN_W+SAMPLE_WIDTH+1:0] prod_d;

    logic                                  sum_valid;
    logic                                  sum_ready;
    logic signed [DRIVE_W-1:0]             sum_drive;
    logic signed [DRIVE_W-1:0]             drive;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next      = gains_reg;
        rate_limit_next = rate_limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:     gains_next.kp   = cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:     gains_next.ki   = cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:     gains_next.kd   = cfg_data[GAIN_W-1:0];
                CFG_RATE_LIMIT: rate_limit_next = cfg_data[LIMIT_W-1:0];
                default:        rate_limit_next = rate_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg      <= '0;
            rate_limit_reg <= '0;
        end
        else
        begin
            gains_reg      <= gains_next;
            rate_limit_reg <= rate_limit_next;
        end
    end

    pwsl_error_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_error (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .target    (s_tdata[SAMPLE_WIDTH-1:0]),
        .measured  (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .error     (error),
        .error_sum (error_sum),
        .delta     (delta)
    );

    pwsl_mult_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .gains     (gains_reg),
        .error     (error),
        .error_sum (error_sum),
        .delta     (delta),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod_p    (prod_p),
        .prod_i    (prod_i),
        .prod_d    (prod_d)
    );

    pwsl_sum_stage #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod_p    (prod_p),
        .prod_i    (prod_i),
        .prod_d    (prod_d),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .drive     (sum_drive)
    );

    pwsl_slew_stage u_slew (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sum_valid),
        .in_ready     (sum_ready),
        .drive_in     (sum_drive),
        .rate_limit   (rate_limit_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .drive        (drive),
        .rate_limited (m_tuser)
    );

    assign m_tdata = drive;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the PID unit with slew limit.
// -----------------------------------------------------------------------------
// A scoreboard class predicts the drive and the limit flag of every sample that
// the unit accepts. It keeps its own error sum, its own last error, its own
// last drive and its own copy of the gains and the rate limit. Results are
// compared in order, field by field. A directed run covers the sample
// extremes, floor rounding, drive saturation and slew clipping. Random
// segments with changing gains and limits follow. Short wind-up runs push
// large errors of one sign into the error sum. Both stream sides idle at
// random in two regimes, and a third regime runs without idles.
// -----------------------------------------------------------------------------
module tb_top;
    import pwsl_pkg::*;

    localparam int SAMPLE_W    = DEF_SAMPLE_WIDTH;
    localparam int FRAC_W      = DEF_FRAC_BITS;
    localparam int IN_W        = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;

    localparam longint DRIVE_HI = (longint'(1) <<< (DRIVE_W - 1)) - 1;
    localparam longint DRIVE_LO = -(longint'(1) <<< (DRIVE_W - 1));
    localparam longint SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO   = -(longint'(1) <<< (SUM_W - 1));

    typedef struct packed {
        logic [DRIVE_W-1:0] drive;
        logic               clipped;
    } drive_result_t;

    class drive_checker;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIMIT_W-1:0]       slew;
        longint                   err_sum;
        longint                   last_err;
        longint                   last_drive;
        drive_result_t            expected_drives[$];
        int                       errors;

        function new();
            kp         = '0;
            ki         = '0;
            kd         = '0;
            slew       = '0;
            err_sum    = 0;
            last_err   = 0;
            last_drive = 0;
            errors     = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            if (v < lo)
                return lo;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_GAIN_P:     kp = value[GAIN_W-1:0];
                CFG_GAIN_I:     ki = value[GAIN_W-1:0];
                CFG_GAIN_D:     kd = value[GAIN_W-1:0];
                CFG_RATE_LIMIT: slew = value[LIMIT_W-1:0];
                default:        ;
            endcase
        endfunction

        function void note_sample(logic [IN_W-1:0] data);
            longint        tgt;
            longint        meas;
            longint        err;
            longint        delta;
            longint        acc;
            longint        drv;
            drive_result_t res;
            tgt   = $signed(data[SAMPLE_W-1:0]);
            meas  = $signed(data[2*SAMPLE_W-1:SAMPLE_W]);
            err   = tgt - meas;
            err_sum = clamp(err_sum + err, SUM_LO, SUM_HI);
            delta = err - last_err;
            last_err = err;
            acc   = longint'(kp) * err + longint'(ki) * err_sum + longint'(kd) * delta;
            // The arithmetic shift rounds toward minus infinity.
            drv   = clamp(acc >>> FRAC_W, DRIVE_LO, DRIVE_HI);
            res.clipped = 1'b0;
            if (slew != 0) begin
                if (drv > last_drive + longint'(slew)) begin
                    drv = last_drive + longint'(slew);
                    res.clipped = 1'b1;
                end else if (drv < last_drive - longint'(slew)) begin
                    drv = last_drive - longint'(slew);
                    res.clipped = 1'b1;
                end
            end
            last_drive = drv;
            res.drive = drv[DRIVE_W-1:0];
            expected_drives.push_back(res);
        endfunction

        task report(string msg);
            $display("%0t ns: ERROR %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [DRIVE_W-1:0] drive, logic clipped);
            drive_result_t want;
            if (expected_drives.size() == 0) begin
                report($sformatf("unexpected result drive=%0d", $signed(drive)));
                return;
            end
            want = expected_drives.pop_front();
            if (drive !== want.drive)
                report($sformatf("drive %0d, expected %0d",
                                 $signed(drive), $signed(want.drive)));
            if (clipped !== want.clipped)
                report($sformatf("rate_limited %b, expected %b", clipped, want.clipped));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata   = '0;     // target, measured
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [DRIVE_W-1:0]     m_tdata;            // drive
    logic                   m_tuser;            // rate_limited
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    drive_checker           drive_chk;
    int                     send_idle_pct  = 0;
    int                     recv_stall_pct = 0;
    int                     quiet_cycles   = 0;
    logic [SAMPLE_W-1:0]    hold_target    = '0;

    pid_with_slew_limit_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every transaction is observed here, so the predictor sees inputs, results
    // and register writes in the order of the clock edges.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                drive_chk.note_sample(s_tdata);
            if (m_tvalid && m_tready)
                drive_chk.check_result(m_tdata, m_tuser);
            if (cfg_valid && cfg_ready)
                drive_chk.set_reg(cfg_index_t'(cfg_index), cfg_data);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Gain writes carry random upper bits, which the unit must drop.
    task automatic write_config(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                                input logic [GAIN_W-1:0] d, input logic [LIMIT_W-1:0] lim);
        put_reg(CFG_GAIN_P, {(CFG_DATA_W - GAIN_W)'($urandom), p});
        put_reg(CFG_GAIN_I, {(CFG_DATA_W - GAIN_W)'($urandom), i});
        put_reg(CFG_GAIN_D, {(CFG_DATA_W - GAIN_W)'($urandom), d});
        put_reg(CFG_RATE_LIMIT, lim);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] tgt, input logic [SAMPLE_W-1:0] meas);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= IN_W'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {meas, tgt};
        do @(posedge clk); while (!s_tready);
    endtask

    // Holds the input side back until every expected drive has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (drive_chk.expected_drives.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_edge();
        case ($urandom_range(3))
            0:       return {1'b1, {(SAMPLE_W - 1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_W - 1){1'b1}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? {1'b0, {(GAIN_W - 1){1'b1}}}
                                              : {1'b1, {(GAIN_W - 1){1'b0}}};
            1:       return GAIN_W'($urandom_range(2048) - 1024);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(4))
            0:       return '0;
            1:       return LIMIT_W'($urandom_range(256, 1));
            2:       return '1;
            default: return LIMIT_W'($urandom);
        endcase
    endfunction

    // Mostly a loop that tracks a held set point with a small measured offset,
    // with some edge values and unrelated pairs mixed in.
    task automatic send_random();
        logic [SAMPLE_W-1:0] tgt;
        logic [SAMPLE_W-1:0] meas;
        if ($urandom_range(19) == 0)
            hold_target = SAMPLE_W'($urandom);
        case ($urandom_range(9))
            0:
            begin
                tgt  = pick_edge();
                meas = pick_edge();
            end
            1, 2:
            begin
                tgt  = SAMPLE_W'($urandom);
                meas = SAMPLE_W'($urandom);
            end
            default:
            begin
                tgt  = hold_target;
                meas = hold_target + SAMPLE_W'($urandom_range(64) - 32);
            end
        endcase
        send_sample(tgt, meas);
    endtask

    task automatic run_segment(input int count);
        write_config(pick_gain(), pick_gain(), pick_gain(), pick_limit());
        repeat (count)
            send_random();
        drain();
    endtask

    initial
    begin
        drive_chk = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sample extremes and floor rounding of a negative product.
        write_config(16'h0180, 16'h0000, 16'h0000, '0);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0001);
        send_sample(16'h0000, 16'h0001);
        drain();

        // Largest gains push the drive past both ends of its range.
        write_config(16'h7FFF, 16'h7FFF, 16'h7FFF, '0);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        drain();

        // Most negative gains with the tightest slew limit.
        write_config(16'h8000, 16'h8000, 16'h8000, 23'd1);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0064, 16'h0000);
        send_sample(16'h0000, 16'h0064);
        send_sample(16'h0000, 16'h0000);
        drain();

        write_config(16'h0100, 16'h0010, 16'hFF80, '1);
        send_sample(16'h0005, 16'h0000);
        send_sample(16'hFFF9, 16'h0003);
        send_sample(16'h1234, 16'h1200);
        send_sample(16'h0000, 16'h0000);
        drain();

        write_config(16'h0080, 16'h0040, 16'h0200, 23'd1000);
        send_sample(16'h2000, 16'h0000);
        send_sample(16'hE000, 16'h0000);
        send_sample(16'h0000, 16'h0000);
        drain();

        send_idle_pct  = 10;
        recv_stall_pct = 79;
        repeat (4)
            run_segment($urandom_range(130, 50));

        send_idle_pct  = 79;
        recv_stall_pct = 10;
        repeat (4)
            run_segment($urandom_range(130, 50));

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4)
            run_segment($urandom_range(130, 50));

        // Large errors of one sign, then of the other, build up the error sum.
        write_config(pick_gain(), pick_gain(), pick_gain(), pick_limit());
        repeat (20)
            send_sample(16'h7FFF - SAMPLE_W'($urandom_range(255)),
                        16'h8000 + SAMPLE_W'($urandom_range(255)));
        drain();
        write_config(pick_gain(), pick_gain(), pick_gain(), pick_limit());
        repeat (20)
            send_sample(16'h8000 + SAMPLE_W'($urandom_range(255)),
                        16'h7FFF - SAMPLE_W'($urandom_range(255)));
        drain();
        run_segment(100);

        repeat (20) @(posedge clk);
        if (drive_chk.expected_drives.size() != 0)
            drive_chk.report($sformatf("%0d expected results never arrived",
                                       drive_chk.expected_drives.size()));
        if (drive_chk.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== pid_with_slew_limit_unit.f =====
src/pwsl_pkg.sv
src/pwsl_error_stage.sv
src/pwsl_mult_stage.sv
src/pwsl_sum_stage.sv
src/pwsl_slew_stage.sv
src/pid_with_slew_limit_unit.sv
test/tb_top.sv
